// ===== rtl/ttip_pkg.sv =====
// shared types and constants of the text to integer parser
package ttip_pkg;

    localparam int CHAR_W          = 8;
    localparam int ACC_W           = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    // configuration register indexes
    localparam logic CFG_SIGNED_MODE = 1'b0;
    localparam logic CFG_WIDE_MODE   = 1'b1;

    // character codes used by the grammar
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_HEXPFX = 3'd3,
        PH_HEX    = 3'd4,
        PH_DEC    = 3'd5,
        PH_TRAIL  = 3'd6,
        PH_ERROR  = 3'd7
    } t_phase;

    // classified character, one queue entry
    typedef struct packed {
        logic       term;
        logic       space;
        logic       plus;
        logic       minus;
        logic       letter_x;
        logic       zero_char;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] digit;
    } t_char_info;

    typedef struct packed {
        logic signed_mode;
        logic wide_mode;
    } t_mode;

endpackage

// ===== rtl/ttip_front.sv =====
// front end: takes character beats and classifies them for the queue
module ttip_front (
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ttip_pkg::CHAR_W-1:0]  i_char_byte,
    output logic                         o_push,
    output ttip_pkg::t_char_info         o_info,
    input  logic                         i_queue_full
);
    import ttip_pkg::*;

    logic [CHAR_W-1:0] w_c;

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;
    assign w_c        = i_char_byte;

    always_comb begin
        o_info           = '0;
        o_info.term      = (w_c == CH_NUL);
        o_info.space     = (w_c == CH_SPACE) || (w_c >= CH_TAB && w_c <= CH_CR);
        o_info.plus      = (w_c == CH_PLUS);
        o_info.minus     = (w_c == CH_MINUS);
        o_info.letter_x  = ((w_c | CASE_BIT) == CH_LO_X);
        o_info.zero_char = (w_c == CH_ZERO);
        priority if (w_c >= CH_ZERO && w_c <= CH_NINE) begin
            o_info.dec_ok = 1'b1;
            o_info.hex_ok = 1'b1;
            o_info.digit  = 4'(w_c - CH_ZERO);
        end else if (w_c >= CH_LO_A && w_c <= CH_LO_F) begin
            o_info.hex_ok = 1'b1;
            o_info.digit  = 4'(w_c - CH_LO_A + 8'd10);
        end else if (w_c >= CH_UP_A && w_c <= CH_UP_F) begin
            o_info.hex_ok = 1'b1;
            o_info.digit  = 4'(w_c - CH_UP_A + 8'd10);
        end else begin
            o_info.digit  = 4'd0;
        end
    end

endmodule

// ===== rtl/ttip_queue.sv =====
// short queue of classified characters between front and back
module ttip_queue #(
    parameter int DEPTH = ttip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ttip_pkg::t_char_info  i_info,
    output logic                  o_full,
    output logic                  o_valid,
    output ttip_pkg::t_char_info  o_info,
    input  logic                  i_pop
);
    import ttip_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_char_info       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_info  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_info;
        end
    end

endmodule

// ===== rtl/ttip_back.sv =====
// back end: grammar state machine, accumulator, range check and result register
module ttip_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ttip_pkg::t_mode              i_mode,
    input  logic                         i_q_valid,
    input  ttip_pkg::t_char_info         i_info,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ttip_pkg::ACC_W-1:0]   o_parsed_value,
    output logic                         o_parse_ok
);
    import ttip_pkg::*;

    t_phase             r_phase, n_phase;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic               r_minus, n_minus;
    logic               r_range, n_range;
    logic               r_out_valid;
    logic [ACC_W-1:0]   r_value;
    logic               r_ok;

    logic               w_take;
    logic               w_fin;
    logic [ACC_W-1:0]   w_mask;
    logic [ACC_W-1:0]   w_limit;
    logic [ACC_W+4:0]   w_prod10;
    logic [ACC_W+4:0]   w_prod16;
    logic [ACC_W+4:0]   w_sum10;
    logic [ACC_W+4:0]   w_sum16;
    logic               w_over10;
    logic               w_over16;
    logic [ACC_W-1:0]   w_val;
    logic [ACC_W-1:0]   w_res;
    logic               w_digits;

    assign w_mask  = {{(ACC_W/2){i_mode.wide_mode}}, {(ACC_W/2){1'b1}}};
    assign w_limit = i_mode.signed_mode ? (w_mask >> 1) : w_mask;

    // true product plus digit, compared against the limit before wrapping
    assign w_prod10 = {2'b0, r_acc, 3'b0} + {4'b0, r_acc, 1'b0};
    assign w_prod16 = {1'b0, r_acc, 4'b0};
    assign w_sum10  = w_prod10 + {{(ACC_W+1){1'b0}}, i_info.digit};
    assign w_sum16  = w_prod16 + {{(ACC_W+1){1'b0}}, i_info.digit};
    assign w_over10 = w_sum10 > {5'b0, w_limit};
    assign w_over16 = w_sum16 > {5'b0, w_limit};

    // terminators wait for the result register, other beats flow freely
    assign o_pop  = i_q_valid && (!i_info.term || !r_out_valid || i_out_ready);
    assign w_take = o_pop;
    assign w_fin  = w_take && i_info.term;

    assign w_val    = r_acc & w_mask;
    assign w_res    = r_minus ? ((~w_val + 1'b1) & w_mask) : w_val;
    assign w_digits = (r_phase == PH_ZERO) || (r_phase == PH_HEX) ||
                      (r_phase == PH_DEC) || (r_phase == PH_TRAIL);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_minus = r_minus;
        n_range = r_range;
        if (w_fin) begin
            n_phase = PH_START;
            n_acc   = '0;
            n_minus = 1'b0;
            n_range = 1'b0;
        end else if (w_take) begin
            unique case (r_phase)
                PH_START, PH_SIGN: begin
                    priority if (r_phase == PH_START && i_info.space) begin
                        n_phase = PH_START;
                    end else if (r_phase == PH_START && i_info.plus) begin
                        n_phase = PH_SIGN;
                    end else if (r_phase == PH_START && i_info.minus &&
                                 i_mode.signed_mode) begin
                        n_minus = 1'b1;
                        n_phase = PH_SIGN;
                    end else if (i_info.zero_char) begin
                        n_phase = PH_ZERO;
                    end else if (i_info.dec_ok) begin
                        n_acc   = w_sum10[ACC_W-1:0] & w_mask;
                        n_range = r_range | w_over10;
                        n_phase = PH_DEC;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_ZERO, PH_DEC: begin
                    priority if (r_phase == PH_ZERO && i_info.letter_x) begin
                        n_phase = PH_HEXPFX;
                    end else if (i_info.dec_ok) begin
                        n_acc   = w_sum10[ACC_W-1:0] & w_mask;
                        n_range = r_range | w_over10;
                        n_phase = PH_DEC;
                    end else if (i_info.space) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_HEXPFX, PH_HEX: begin
                    priority if (i_info.hex_ok) begin
                        n_acc   = w_sum16[ACC_W-1:0] & w_mask;
                        n_range = r_range | w_over16;
                        n_phase = PH_HEX;
                    end else if (r_phase == PH_HEX && i_info.space) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_TRAIL: begin
                    if (!i_info.space) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_ERROR: begin
                    n_phase = PH_ERROR;
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_acc       <= '0;
            r_minus     <= 1'b0;
            r_range     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_minus <= n_minus;
            r_range <= n_range;
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_value <= w_res;
            r_ok    <= w_digits && !r_range;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_value;
    assign o_parse_ok     = r_ok;

endmodule

// ===== rtl/text_to_integer_parser.sv =====
// top level of the streaming text to integer parser
// throughput: one character beat per cycle, terminators included, while results are taken
// result path: an accepted terminating zero is written into the queue, then the grammar stage
//   pops it and loads the result register
// the per-character shift-add plus range compare in the back end sets the cycle time
// reset: synchronous, active low; clears queue, parser state and result valid,
//   signed_mode returns to 1 and wide_mode to 0
module text_to_integer_parser #(
    parameter int QUEUE_DEPTH = ttip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic                         i_cfg_data,
    // character input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ttip_pkg::CHAR_W-1:0]  i_char_byte,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ttip_pkg::ACC_W-1:0]   o_parsed_value,
    output logic                         o_parse_ok
);
    import ttip_pkg::*;

    // mode registers, read live by the back end on every beat
    logic       r_signed_mode;
    logic       r_wide_mode;
    t_mode      w_mode;

    // front to queue
    logic       w_push;
    t_char_info w_front_info;
    logic       w_full;

    // queue to back
    logic       w_q_valid;
    t_char_info w_q_info;
    logic       w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
            r_wide_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIGNED_MODE: r_signed_mode <= i_cfg_data;
                CFG_WIDE_MODE:   r_wide_mode   <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    assign w_mode.signed_mode = r_signed_mode;
    assign w_mode.wide_mode   = r_wide_mode;

    // front: handshake and character classification
    ttip_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_byte  (i_char_byte),
        .o_push       (w_push),
        .o_info       (w_front_info),
        .i_queue_full (w_full)
    );

    // queue decouples intake from the grammar stage
    ttip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_info  (w_front_info),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_info  (w_q_info),
        .i_pop   (w_pop)
    );

    // back: grammar, accumulation, range tracking, result register
    ttip_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (w_mode),
        .i_q_valid      (w_q_valid),
        .i_info         (w_q_info),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_parsed_value (o_parsed_value),
        .o_parse_ok     (o_parse_ok)
    );

endmodule

// ===== tb/text_to_integer_parser_tb.sv =====
// self-checking testbench of the streaming text to integer parser
`timescale 1ns / 100ps

module text_to_integer_parser_tb;
    import ttip_pkg::*;

    localparam int RANDOM_CHARS    = 950;
    localparam int STRINGS_PER_SET = 20;
    localparam int SETTLE_CYCLES   = 6;     // idle wait after the last result is back
    localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
    localparam int QUIET_LIMIT     = 4000;  // cycles with no beat on either side

    // one parse result as seen on the output channel
    typedef struct packed {
        logic [63:0] value;
        logic        ok;
    } t_result;

    // directed row attributes, text is kept in a parallel queue
    typedef struct packed {
        logic        sgn;
        logic        wide;
        logic        typed;
        logic [63:0] value;
        logic        ok;
    } t_row;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = CFG_SIGNED_MODE;
    logic                cfg_data  = 1'b0;
    logic                in_valid  = 1'b0;
    logic [CHAR_W-1:0]   in_char   = CH_NUL;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic [ACC_W-1:0]    parsed_value;
    logic                parse_ok;

    // predictor state
    t_phase              cur_phase;
    logic [63:0]         cur_mag;
    logic                cur_neg;
    logic                cur_over;
    logic                mode_signed;
    logic                mode_wide;

    t_result             pending_results[$];
    t_result             typed_result;
    logic                typed_armed = 1'b0;

    logic [CHAR_W-1:0]   text_buf[$];
    string               row_text[$];
    t_row                row_info[$];

    logic                src_gaps  = 1'b1;
    logic                sink_gaps = 1'b1;
    logic                hold_req  = 1'b0;
    int                  chars_sent;
    int                  mismatches   = 0;
    int                  quiet_cycles = 0;
    t_result             want;

    text_to_integer_parser u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_char_byte    (in_char),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_parsed_value (parsed_value),
        .o_parse_ok     (parse_ok)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] width_ones();
        return mode_wide ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void restart_string();
        cur_phase = PH_START;
        cur_mag   = '0;
        cur_neg   = 1'b0;
        cur_over  = 1'b0;
    endfunction

    // shift-add of one digit, range flag is sticky
    function automatic void shift_in(input logic [63:0] radix, input logic [3:0] digit);
        logic [63:0] ones;
        logic [63:0] lim;
        ones = width_ones();
        lim  = mode_signed ? ones >> 1 : ones;
        if (cur_mag > (lim - 64'(digit)) / radix) cur_over = 1'b1;
        cur_mag = (cur_mag * radix + 64'(digit)) & ones;
    endfunction

    // one accepted character beat, a terminator queues the expected result
    function automatic void parse_char(input logic [7:0] c);
        logic [63:0] ones;
        logic [63:0] v;
        logic [3:0]  dv;
        logic        is_dec;
        logic        is_hex;
        t_result     r;
        ones   = width_ones();
        is_dec = c >= CH_ZERO && c <= CH_NINE;
        is_hex = is_dec || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
        dv     = is_dec ? 4'(c - CH_ZERO) : 4'((c | CASE_BIT) - CH_LO_A + 8'd10);

        if (c == CH_NUL) begin
            v = cur_mag & ones;
            if (cur_neg) v = (64'd0 - v) & ones;
            r.value = v;
            r.ok    = !cur_over && (cur_phase == PH_ZERO || cur_phase == PH_HEX ||
                                    cur_phase == PH_DEC  || cur_phase == PH_TRAIL);
            pending_results.push_back(typed_armed ? typed_result : r);
            typed_armed = 1'b0;
            restart_string();
            return;
        end

        case (cur_phase)
            PH_START, PH_SIGN: begin
                if (cur_phase == PH_START && is_blank(c)) cur_phase = PH_START;
                else if (cur_phase == PH_START && c == CH_PLUS) cur_phase = PH_SIGN;
                else if (cur_phase == PH_START && c == CH_MINUS && mode_signed) begin
                    cur_neg   = 1'b1;
                    cur_phase = PH_SIGN;
                end else if (c == CH_ZERO) cur_phase = PH_ZERO;
                else if (is_dec) begin
                    shift_in(64'd10, dv);
                    cur_phase = PH_DEC;
                end else cur_phase = PH_ERROR;
            end
            PH_ZERO, PH_DEC: begin
                // a lone zero not followed by x is just a decimal digit
                if (cur_phase == PH_ZERO && (c | CASE_BIT) == CH_LO_X) cur_phase = PH_HEXPFX;
                else if (is_dec) begin
                    shift_in(64'd10, dv);
                    cur_phase = PH_DEC;
                end else if (is_blank(c)) cur_phase = PH_TRAIL;
                else cur_phase = PH_ERROR;
            end
            PH_HEXPFX, PH_HEX: begin
                if (is_hex) begin
                    shift_in(64'd16, dv);
                    cur_phase = PH_HEX;
                end else if (cur_phase == PH_HEX && is_blank(c)) cur_phase = PH_TRAIL;
                else cur_phase = PH_ERROR;
            end
            PH_TRAIL: begin
                if (!is_blank(c)) cur_phase = PH_ERROR;
            end
            default: cur_phase = PH_ERROR;
        endcase
    endfunction

    // ---------------------------------------------------------------- text builders

    function automatic logic [7:0] rand_blank();
        int k;
        k = $urandom_range(5);
        return k == 5 ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    function automatic void push_string(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    // random string body, mostly well formed with random content
    function automatic void build_text();
        int          kind;
        int          n;
        int          k;
        logic [64:0] big;
        text_buf.delete();
        kind = $urandom_range(99);
        if (kind < 60 || (kind >= 75 && kind < 85)) begin
            n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n) text_buf.push_back(rand_blank());
            k = $urandom_range(9);
            if (k < 3) text_buf.push_back(CH_PLUS);
            else if (k < 6) text_buf.push_back(CH_MINUS);
            if (kind < 40 || (kind >= 75 && $urandom_range(1) == 0)) begin
                n = $urandom_range(1) ? $urandom_range(1, 5) : $urandom_range(6, 21);
                repeat (n) text_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
            end else begin
                text_buf.push_back(CH_ZERO);
                text_buf.push_back($urandom_range(1) ? CH_LO_X : (CH_LO_X ^ CASE_BIT));
                n = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(5, 17);
                repeat (n) begin
                    k = $urandom_range(15);
                    if (k < 10) text_buf.push_back(CH_ZERO + 8'(k));
                    else text_buf.push_back(($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(k - 10));
                end
            end
            n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n) text_buf.push_back(rand_blank());
            // broken sequence: one byte replaced by anything non-zero
            if (kind >= 75) begin
                k = $urandom_range(text_buf.size() - 1);
                text_buf[k] = 8'($urandom_range(1, 255));
            end
        end else if (kind < 75) begin
            // around the 32/64-bit signed and unsigned limits
            case ($urandom_range(3))
                0: big = 65'd1 << 31;
                1: big = 65'd1 << 32;
                2: big = 65'd1 << 63;
                default: big = 65'd1 << 64;
            endcase
            big = big + 65'($urandom_range(4)) - 65'd2;
            if ($urandom_range(2) == 0) text_buf.push_back(CH_MINUS);
            if ($urandom_range(1)) push_string({"0x", $sformatf("%0h", big)});
            else push_string($sformatf("%0d", big));
        end else if (kind < 95) begin
            // noise, high bytes included
            n = $urandom_range(6);
            repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
            // digitless strings
            case ($urandom_range(3))
                0: ;
                1: repeat ($urandom_range(1, 3)) text_buf.push_back(rand_blank());
                2: text_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                default: push_string("0x");
            endcase
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // one character beat, optional idle cycles ahead of it
    task automatic offer_char(input logic [7:0] c);
        if (src_gaps && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 35) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input logic close);
        for (int i = 0; i < text_buf.size(); i++) offer_char(text_buf[i]);
        if (close) offer_char(CH_NUL);
    endtask

    // sender pauses until every result is back and the pipe is empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_modes(input logic sgn, input logic wide);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIGNED_MODE;
        cfg_data  <= sgn;
        @(posedge clk);
        cfg_index <= CFG_WIDE_MODE;
        cfg_data  <= wide;
        @(posedge clk);
        cfg_we      <= 1'b0;
        mode_signed = sgn;
        mode_wide   = wide;
    endtask

    task automatic add_row(input logic sgn, input logic wide, input string s,
                           input logic typed, input logic [63:0] value, input logic ok);
        t_row r;
        r.sgn   = sgn;
        r.wide  = wide;
        r.typed = typed;
        r.value = value;
        r.ok    = ok;
        row_info.push_back(r);
        row_text.push_back(s);
    endtask

    // receiver: random stalls, or one long hold-off counted here
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= !(sink_gaps && $urandom_range(99) < 35);
            end
        end
    end

    // ---------------------------------------------------------------- checker

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", '0, parsed_value);
                end else begin
                    want = pending_results.pop_front();
                    if (want.value !== parsed_value)
                        report_mismatch("parsed_value", want.value, parsed_value);
                    if (want.ok !== parse_ok)
                        report_mismatch("parse_ok", 64'(want.ok), 64'(parse_ok));
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[text_to_integer_parser] ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        int set_no;
        int in_set;

        // directed strings, typed expectations only for the obvious ones
        add_row(1, 0, "",                               1, 64'h0, 0);   // empty
        add_row(1, 0, " \011\012\013\014\015+",         1, 64'h0, 0);   // blanks and sign only
        add_row(1, 0, "2147483647",                     1, 64'h7FFF_FFFF, 1);
        add_row(1, 0, "-2147483648",                    1, 64'h8000_0000, 0);
        add_row(1, 0, "-2147483647",                    1, 64'h8000_0001, 1);
        add_row(1, 0, "0x7fffFFFF \011",                1, 64'h7FFF_FFFF, 1);
        add_row(1, 0, "0X",                             1, 64'h0, 0);   // prefix, no digit
        add_row(1, 0, "00123",                          0, 64'h0, 0);
        add_row(1, 0, "12 3",                           1, 64'hC, 0);   // digit after trailing blank
        add_row(1, 0, "+ 5",                            1, 64'h0, 0);   // blank after sign
        add_row(1, 0, "7\377\200",                      1, 64'h7, 0);   // high bytes
        add_row(0, 0, "-1",                             1, 64'h0, 0);   // minus when unsigned
        add_row(0, 0, "4294967295",                     1, 64'hFFFF_FFFF, 1);
        add_row(0, 0, "4294967296",                     1, 64'h0, 0);
        add_row(0, 1, "18446744073709551615",           1, {64{1'b1}}, 1);
        add_row(0, 1, "0x10000000000000000",            1, 64'h0, 0);
        add_row(1, 1, "-9223372036854775807",           1, 64'h8000_0000_0000_0001, 1);
        add_row(1, 1, "0xfedcba9876543210",             0, 64'h0, 0);
        add_row(1, 1, "-0x1aB",                         0, 64'h0, 0);

        // synchronous reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        mode_signed = 1'b1;
        mode_wide   = 1'b0;
        restart_string();
        @(posedge clk);

        for (int i = 0; i < row_text.size(); i++) begin
            if (row_info[i].sgn != mode_signed || row_info[i].wide != mode_wide) begin
                wait_idle();
                write_modes(row_info[i].sgn, row_info[i].wide);
            end
            text_buf.delete();
            push_string(row_text[i]);
            typed_armed        = row_info[i].typed;
            typed_result.value = row_info[i].value;
            typed_result.ok    = row_info[i].ok;
            send_text(1'b1);
        end

        // mode change inside a string: 32-bit digits first, 64-bit range after
        wait_idle();
        write_modes(1'b1, 1'b0);
        text_buf.delete();
        push_string("-30000000");
        send_text(1'b0);
        wait_idle();
        write_modes(1'b1, 1'b1);
        text_buf.delete();
        push_string("000");
        send_text(1'b1);

        // random strings in sets, each set with its own modes
        chars_sent = 0;
        set_no     = 0;
        in_set     = 0;
        while (chars_sent < RANDOM_CHARS) begin
            if (in_set == 0) begin
                wait_idle();
                // first four sets walk every mode combination
                if (set_no < 4) write_modes(set_no[0], set_no[1]);
                else write_modes(1'($urandom_range(1)), 1'($urandom_range(1)));
                // set 1 runs without any idling, set 2 fills up behind a hold-off
                src_gaps  = (set_no != 1 && set_no != 2);
                sink_gaps = (set_no != 1);
                if (set_no == 2) hold_req = 1'b1;
            end
            build_text();
            send_text(1'b1);
            in_set++;
            if (in_set == STRINGS_PER_SET) begin
                in_set = 0;
                set_no++;
            end
        end

        // drain and let the pipe settle
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("[text_to_integer_parser] OK");
        else
            $display("[text_to_integer_parser] ERROR");
        $finish;
    end

endmodule
